// ===== sv/ebu_pkg.sv =====
// ----------------------------------------------------------------------------
// ebu_pkg
// Constants shared by the escape byte unstuffing decoder: escape and decoded
// byte codes, configuration register indexes and suffix reset values.
// ----------------------------------------------------------------------------
package ebu_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h1B;

    localparam logic [BYTE_W-1:0] DEC_UNIT_SEP   = 8'h1F;
    localparam logic [BYTE_W-1:0] DEC_RECORD_SEP = 8'h1E;
    localparam logic [BYTE_W-1:0] DEC_FILE_SEP   = 8'h1C;
    localparam logic [BYTE_W-1:0] DEC_ESCAPE     = 8'h1B;
    localparam logic [BYTE_W-1:0] DEC_GROUP_SEP  = 8'h1D;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT_SEP   = 3'd0,
        CFG_RECORD_SEP = 3'd1,
        CFG_FILE_SEP   = 3'd2,
        CFG_ESCAPE     = 3'd3,
        CFG_GROUP_SEP  = 3'd4
    } t_cfg_idx;

    localparam logic [BYTE_W-1:0] RST_UNIT_SEP   = 8'd95;
    localparam logic [BYTE_W-1:0] RST_RECORD_SEP = 8'd94;
    localparam logic [BYTE_W-1:0] RST_FILE_SEP   = 8'd92;
    localparam logic [BYTE_W-1:0] RST_ESCAPE     = 8'd91;
    localparam logic [BYTE_W-1:0] RST_GROUP_SEP  = 8'd93;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              frame_end;
        logic              frame_error;
    } t_result;

endpackage

// ===== sv/escape_byte_unstuffing_decoder_core.sv =====
// ----------------------------------------------------------------------------
// escape_byte_unstuffing_decoder_core
// Removes escape pairs from a byte stream and flags malformed frames.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one escaped byte per transfer, tlast marks the frame end.
//   Master stream: one decoded result per transfer; tdata is the byte,
//   tuser carries has_byte and frame_error, tlast the frame end.
//   An escape byte, a suffix after an error and bytes after an error give no
//   result. A frame with an error ends with one result with tuser frame_error
//   set and no byte; bytes of that frame already sent must be discarded.
//   Config channel: write suffix registers 0..4 while the stream is idle;
//   other indexes are ignored. It is always ready.
//   Each input transfer passes the input register, then the result register.
//   Throughput: one byte per cycle while the master side takes results,
//   set by the single decode step between the two registers.
//   Reset: synchronous active low; clears both stages, escape and error state,
//   and loads the default suffix codes.
//   Stall: while the master side holds tready low the result register holds;
//   one more byte is taken into the input register, then tready drops.
// ----------------------------------------------------------------------------
module escape_byte_unstuffing_decoder_core
    import ebu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] in_byte
    input  logic                 s_axis_tlast,   // in_frame_end

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [BYTE_W-1:0]    m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]           m_axis_tuser,   // [0] out_has_byte, [1] frame_error
    output logic                 m_axis_tlast,   // out_frame_end

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic [BYTE_W-1:0] r_sfx_us, r_sfx_rs, r_sfx_fs, r_sfx_esc, r_sfx_gs;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic              r_esc_pending, n_esc_pending;
    logic              r_err_seen,    n_err_seen;

    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;
    logic              n_out_valid;

    logic              adv;
    logic              in_xfer;
    logic              out_xfer;
    logic              cfg_xfer;

    assign o_cfg_ready   = 1'b1;
    assign cfg_xfer      = i_cfg_valid;
    assign out_xfer      = r_out_valid && m_axis_tready;
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sfx_us  <= RST_UNIT_SEP;
            r_sfx_rs  <= RST_RECORD_SEP;
            r_sfx_fs  <= RST_FILE_SEP;
            r_sfx_esc <= RST_ESCAPE;
            r_sfx_gs  <= RST_GROUP_SEP;
        end else if (cfg_xfer) begin
            case (i_cfg_index)
                CFG_UNIT_SEP:   r_sfx_us  <= i_cfg_data;
                CFG_RECORD_SEP: r_sfx_rs  <= i_cfg_data;
                CFG_FILE_SEP:   r_sfx_fs  <= i_cfg_data;
                CFG_ESCAPE:     r_sfx_esc <= i_cfg_data;
                CFG_GROUP_SEP:  r_sfx_gs  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_esc_pending = r_esc_pending;
        n_err_seen    = r_err_seen;
        n_out_valid   = 1'b0;
        n_out         = '0;
        if (r_err_seen) begin
            if (r_in_last) begin
                n_out_valid       = 1'b1;
                n_out.frame_end   = 1'b1;
                n_out.frame_error = 1'b1;
            end
        end else if (r_esc_pending) begin
            n_esc_pending = 1'b0;
            n_out.has_byte  = 1'b1;
            n_out.frame_end = r_in_last;
            n_out_valid     = 1'b1;
            if (r_in_byte == r_sfx_us) begin
                n_out.out_byte = DEC_UNIT_SEP;
            end else if (r_in_byte == r_sfx_rs) begin
                n_out.out_byte = DEC_RECORD_SEP;
            end else if (r_in_byte == r_sfx_fs) begin
                n_out.out_byte = DEC_FILE_SEP;
            end else if (r_in_byte == r_sfx_esc) begin
                n_out.out_byte = DEC_ESCAPE;
            end else if (r_in_byte == r_sfx_gs) begin
                n_out.out_byte = DEC_GROUP_SEP;
            end else begin
                n_out          = '0;
                n_out_valid    = r_in_last;
                n_out.frame_end   = r_in_last;
                n_out.frame_error = r_in_last;
                n_err_seen        = 1'b1;
            end
        end else if (r_in_byte == ESC_BYTE) begin
            n_esc_pending = 1'b1;
            if (r_in_last) begin
                n_out_valid       = 1'b1;
                n_out.frame_end   = 1'b1;
                n_out.frame_error = 1'b1;
            end
        end else begin
            n_out_valid     = 1'b1;
            n_out.out_byte  = r_in_byte;
            n_out.has_byte  = 1'b1;
            n_out.frame_end = r_in_last;
        end
        if (r_in_last) begin
            n_esc_pending = 1'b0;
            n_err_seen    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_esc_pending <= 1'b0;
            r_err_seen    <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid   <= n_out_valid;
                r_esc_pending <= n_esc_pending;
                r_err_seen    <= n_err_seen;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.out_byte;
    assign m_axis_tuser  = {r_out.frame_error, r_out.has_byte};
    assign m_axis_tlast  = r_out.frame_end;

`ifndef SYNTHESIS
    a_err_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_error |-> !r_out.has_byte && r_out.frame_end
            && r_out.out_byte == '0)
        else $error("error result carries a byte or lacks frame end");

    a_state_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_esc_pending && r_err_seen))
        else $error("escape pending and error seen both set");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("input register lost a byte under stall");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> !r_esc_pending && !r_err_seen)
        else $error("frame end did not clear decoder state");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for escape_byte_unstuffing_decoder_core. A local
// unstuffing predictor follows every accepted input transfer and queues the
// decoded result it implies; a monitor compares each output transfer field
// by field against the oldest queued result. Directed frames cover plain
// bytes, every suffix, dangling and unknown escapes, dropped bytes after an
// error, duplicate and extreme suffix codes and ignored register indexes.
// Random frames then run under three idle mixes with a long output stall.
// ----------------------------------------------------------------------------
module tb;
    import ebu_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RST_CYCLES     = 5;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int NUM_SUFFIX     = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]    i_cfg_data;

    // predictor state
    logic [BYTE_W-1:0] sfx_code [NUM_SUFFIX];
    logic              esc_open;
    logic              err_sticky;

    t_result pending_results [$];
    int      mismatches;
    int      bytes_sent;
    int      src_idle_pct;
    int      sink_idle_pct;
    int      sink_hold;
    int      quiet_cycles;

    escape_byte_unstuffing_decoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic bit unstuff_byte(input logic [BYTE_W-1:0] b, input logic last,
                                        output t_result res);
        bit hit;
        bit fail;
        hit  = 1'b0;
        fail = 1'b0;
        res  = '0;
        if (err_sticky) begin
            if (!last) return 1'b0;
            fail = 1'b1;
        end else if (esc_open) begin
            esc_open = 1'b0;
            for (int k = 0; k < NUM_SUFFIX; k++) begin
                if (!hit && b == sfx_code[k]) begin
                    hit = 1'b1;
                    case (k)
                        CFG_UNIT_SEP:   res.out_byte = DEC_UNIT_SEP;
                        CFG_RECORD_SEP: res.out_byte = DEC_RECORD_SEP;
                        CFG_FILE_SEP:   res.out_byte = DEC_FILE_SEP;
                        CFG_ESCAPE:     res.out_byte = DEC_ESCAPE;
                        default:        res.out_byte = DEC_GROUP_SEP;
                    endcase
                end
            end
            if (!hit) begin
                if (!last) begin
                    err_sticky = 1'b1;
                    return 1'b0;
                end
                fail = 1'b1;
            end
        end else if (b == ESC_BYTE) begin
            if (!last) begin
                esc_open = 1'b1;
                return 1'b0;
            end
            fail = 1'b1;
        end else begin
            res.out_byte = b;
        end
        if (fail) begin
            esc_open        = 1'b0;
            err_sticky      = 1'b0;
            res.frame_end   = 1'b1;
            res.frame_error = 1'b1;
        end else begin
            res.has_byte  = 1'b1;
            res.frame_end = last;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR: %s got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // hold tvalid high after a transfer; the next call lowers or reloads it
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_result res;
        @(negedge i_clk);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        if (unstuff_byte(b, last, res)) pending_results.push_back(res);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx <= CFG_GROUP_SEP) sfx_code[idx] = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_frame(input int noise_pct);
        int                len;
        int                n;
        logic [BYTE_W-1:0] b;
        len = $urandom_range(12, 1);
        n   = 0;
        while (n < len) begin
            if (n < len - 1 && $urandom_range(99, 0) < 25) begin
                send_byte(ESC_BYTE, 1'b0);
                if ($urandom_range(99, 0) < noise_pct) b = BYTE_W'($urandom);
                else b = sfx_code[$urandom_range(NUM_SUFFIX - 1, 0)];
                send_byte(b, n + 1 == len - 1);
                n += 2;
            end else begin
                if ($urandom_range(99, 0) < noise_pct) begin
                    b = (n == len - 1) ? ESC_BYTE : BYTE_W'($urandom);
                end else begin
                    b = BYTE_W'($urandom);
                    if (b == ESC_BYTE) b = b ^ 8'h01;
                end
                send_byte(b, n == len - 1);
                n++;
            end
        end
    endtask

    task automatic test_default_suffixes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(RST_UNIT_SEP, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(RST_RECORD_SEP, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(RST_FILE_SEP, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(RST_ESCAPE, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(RST_GROUP_SEP, 1'b1);
        send_byte(ESC_BYTE, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(ESC_BYTE, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_suffix_extremes();
        for (int k = 0; k < NUM_SUFFIX; k++) write_reg(CFG_IDX_W'(k), 8'h00);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_results_drained();
        for (int k = 0; k < NUM_SUFFIX; k++) write_reg(CFG_IDX_W'(k), 8'hFF);
        write_reg(CFG_IDX_W'(CFG_GROUP_SEP + 1), 8'h00);
        write_reg(CFG_IDX_W'(CFG_IDX_MAX - 1), 8'h00);
        write_reg(CFG_IDX_MAX, 8'h00);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_results_drained();
        write_reg(CFG_UNIT_SEP, 8'h01);
        write_reg(CFG_RECORD_SEP, 8'h02);
        write_reg(CFG_FILE_SEP, 8'h04);
        write_reg(CFG_ESCAPE, ESC_BYTE);
        write_reg(CFG_GROUP_SEP, 8'h80);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(ESC_BYTE, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int items);
        int start;
        for (int k = 0; k < NUM_SUFFIX; k++) write_reg(CFG_IDX_W'(k), BYTE_W'($urandom));
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        start = bytes_sent;
        while (bytes_sent - start < items) random_frame(10);
        wait_results_drained();
    endtask

    task automatic test_output_stall();
        int start;
        src_idle_pct  = 0;
        sink_idle_pct = 20;
        sink_hold     = 300;
        start = bytes_sent;
        while (bytes_sent - start < 40) random_frame(10);
        wait_results_drained();
    endtask

    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            m_axis_tready = 1'b0;
            sink_hold--;
        end else begin
            m_axis_tready = ($urandom_range(99, 0) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.out_byte)
                    report_mismatch("out_byte", m_axis_tdata, want.out_byte);
                if (m_axis_tuser[0] !== want.has_byte)
                    report_mismatch("has_byte", m_axis_tuser[0], want.has_byte);
                if (m_axis_tuser[1] !== want.frame_error)
                    report_mismatch("frame_error", m_axis_tuser[1], want.frame_error);
                if (m_axis_tlast !== want.frame_end)
                    report_mismatch("frame_end", m_axis_tlast, want.frame_end);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired at %0t", $realtime);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        mismatches    = 0;
        bytes_sent    = 0;
        quiet_cycles  = 0;
        sink_hold     = 0;
        src_idle_pct  = 35;
        sink_idle_pct = 88;
        esc_open      = 1'b0;
        err_sticky    = 1'b0;
        sfx_code[CFG_UNIT_SEP]   = RST_UNIT_SEP;
        sfx_code[CFG_RECORD_SEP] = RST_RECORD_SEP;
        sfx_code[CFG_FILE_SEP]   = RST_FILE_SEP;
        sfx_code[CFG_ESCAPE]     = RST_ESCAPE;
        sfx_code[CFG_GROUP_SEP]  = RST_GROUP_SEP;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_suffixes();
        test_suffix_extremes();
        test_random_traffic(35, 88, 300);
        test_output_stall();
        test_random_traffic(88, 35, 300);
        test_random_traffic(0, 0, 310);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ebu_pkg.sv
sv/escape_byte_unstuffing_decoder_core.sv
tb/sv/tb.sv
